/* rtl/rqt_pkg.sv */
// ----------------------------------------------------------------------------
// rqt_pkg
// Shared constants and helpers of the read quality trimmer: register indexes,
// quality encoding codes and offsets, running sum limits, stream field widths.
// ----------------------------------------------------------------------------
package rqt_pkg;

	// configuration register indexes
	localparam logic REG_TRIM_THRESHOLD  = 1'b0;
	localparam logic REG_ENCODING_SELECT = 1'b1;

	localparam int THR_W = 7;
	localparam int ENC_W = 2;
	localparam int CFG_W = 7;

	// quality encoding codes
	localparam logic [ENC_W-1:0] ENC_PHRED33 = 2'd0;
	localparam logic [ENC_W-1:0] ENC_PHRED59 = 2'd1;
	localparam logic [ENC_W-1:0] ENC_PHRED64 = 2'd2;
	localparam logic [ENC_W-1:0] ENC_PHRED66 = 2'd3;

	localparam logic [THR_W-1:0] THR_RESET = 7'd20;
	localparam logic [ENC_W-1:0] ENC_RESET = ENC_PHRED33;

	// running sum, signed, saturating
	localparam int                SUM_W   = 20;
	localparam logic [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam int                DELTA_W = 10;

	// stream field widths
	localparam int QUAL_W   = 8;
	localparam int OPLEN_W  = 11;
	localparam int TRIM_W   = 11;
	localparam int NLEN_W   = 11;
	localparam int NSTART_W = 10;
	localparam int NEND_W   = 11;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 48;

	function automatic logic [THR_W-1:0] enc_offset(input logic [ENC_W-1:0] sel);
		logic [THR_W-1:0] off;
		case (sel)
			ENC_PHRED33: off = 7'd33;
			ENC_PHRED59: off = 7'd59;
			ENC_PHRED64: off = 7'd64;
			ENC_PHRED66: off = 7'd66;
			default:     off = 7'd33;
		endcase
		return off;
	endfunction

endpackage

/* rtl/read_quality_trimmer_unit.sv */
// ----------------------------------------------------------------------------
// read_quality_trimmer_unit
// 3'-end quality trimming of one sequencing read, one quality byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Quality bytes of a read enter on the slave stream, 3' end first, with tlast
// on the final byte; one result per read leaves on the master stream after the
// last byte. The block takes one byte every cycle unless a last byte stalls: a
// byte is registered, then one add, one saturation and one compare against the
// best sum update the read state. The result of a read is registered once its
// last byte leaves the input register and sits in an output register, so the
// next read keeps streaming in while the result waits; only a last byte stalls
// behind an untaken result. The user must write threshold and encoding through
// the cfg port only while no read is in flight; the block does not enforce it.
module read_quality_trimmer_unit #(
	parameter int MAX_READ_LENGTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [rqt_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] quality_byte, [18:8] end_op_length, [23:19] zero
	input  logic [rqt_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                           s_tlast,
	// [0] reverse_strand
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [10:0] trim_count, [21:11] new_length, [31:22] start_offset,
	// [42:32] new_end_op_length, [47:43] zero
	output logic [rqt_pkg::M_DATA_W-1:0]   m_tdata
);

	localparam int CW = $clog2(MAX_READ_LENGTH + 1);
	localparam int PW = $clog2(MAX_READ_LENGTH);
	localparam int EW = (CW > rqt_pkg::OPLEN_W) ? CW : rqt_pkg::OPLEN_W;
	localparam logic [CW-1:0] MAX_LEN = CW'(MAX_READ_LENGTH);

	logic [rqt_pkg::THR_W-1:0] trim_threshold_q;
	logic [rqt_pkg::ENC_W-1:0] encoding_select_q;

	logic                          valid_s1;
	logic [rqt_pkg::QUAL_W-1:0]    qual_s1;
	logic [rqt_pkg::OPLEN_W-1:0]   oplen_s1;
	logic                          last_s1;
	logic                          rev_s1;

	logic [rqt_pkg::SUM_W-1:0]     running_sum_q;
	logic [rqt_pkg::SUM_W-1:0]     best_sum_q;
	logic [PW-1:0]                 best_position_q;
	logic [CW-1:0]                 base_count_q;
	logic                          no_trim_q;
	logic                          strand_q;

	logic                          m_valid_q;
	logic [rqt_pkg::M_DATA_W-1:0]  m_data_q;

	logic                          advance;
	logic                          active;
	logic                          first;
	logic [rqt_pkg::DELTA_W-1:0]   qual_adj;
	logic [rqt_pkg::DELTA_W-1:0]   delta;
	logic                          no_trim_eff;
	logic                          strand_eff;
	logic [rqt_pkg::SUM_W:0]       sum_wide;
	logic [rqt_pkg::SUM_W-1:0]     sum_sat;
	logic                          do_sum;
	logic                          new_best;
	logic [rqt_pkg::SUM_W-1:0]     running_sum_d;
	logic [rqt_pkg::SUM_W-1:0]     best_sum_d;
	logic [PW-1:0]                 best_position_d;
	logic [CW-1:0]                 len_d;
	logic [CW-1:0]                 trim_x;
	logic [CW-1:0]                 trim_raw;
	logic [CW-1:0]                 len_m1;
	logic [CW-1:0]                 nstart;
	logic [EW-1:0]                 nend;
	logic [rqt_pkg::M_DATA_W-1:0]  result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_threshold_q  <= rqt_pkg::THR_RESET;
			encoding_select_q <= rqt_pkg::ENC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rqt_pkg::REG_TRIM_THRESHOLD:  trim_threshold_q  <= cfg_data;
				rqt_pkg::REG_ENCODING_SELECT: encoding_select_q <= cfg_data[rqt_pkg::ENC_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			qual_s1  <= s_tdata[rqt_pkg::QUAL_W-1:0];
			oplen_s1 <= s_tdata[rqt_pkg::QUAL_W +: rqt_pkg::OPLEN_W];
			last_s1  <= s_tlast;
			rev_s1   <= s_tuser;
		end
	end

	// per-byte update
	always_comb begin
		active      = base_count_q < MAX_LEN;
		first       = base_count_q == '0;
		qual_adj    = {2'b00, qual_s1}
			- {{(rqt_pkg::DELTA_W-rqt_pkg::THR_W){1'b0}}, rqt_pkg::enc_offset(encoding_select_q)};
		delta       = {{(rqt_pkg::DELTA_W-rqt_pkg::THR_W){1'b0}}, trim_threshold_q} - qual_adj;
		no_trim_eff = first ? (delta[rqt_pkg::DELTA_W-1] || delta == '0) : no_trim_q;
		strand_eff  = first ? rev_s1 : strand_q;

		sum_wide = {running_sum_q[rqt_pkg::SUM_W-1], running_sum_q}
			+ {{(rqt_pkg::SUM_W+1-rqt_pkg::DELTA_W){delta[rqt_pkg::DELTA_W-1]}}, delta};
		if (sum_wide[rqt_pkg::SUM_W] != sum_wide[rqt_pkg::SUM_W-1]) begin
			sum_sat = sum_wide[rqt_pkg::SUM_W] ? rqt_pkg::SUM_MIN : rqt_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_wide[rqt_pkg::SUM_W-1:0];
		end

		do_sum   = active && !no_trim_eff;
		new_best = $signed(sum_sat) > $signed(best_sum_q);

		running_sum_d   = do_sum ? sum_sat : running_sum_q;
		best_sum_d      = (do_sum && new_best) ? sum_sat : best_sum_q;
		best_position_d = (do_sum && new_best) ? base_count_q[PW-1:0] : best_position_q;
		len_d           = active ? base_count_q + CW'(1) : base_count_q;

		trim_raw = no_trim_eff ? '0 : {{(CW-PW){1'b0}}, best_position_d} + CW'(1);
		trim_x   = (trim_raw > len_d) ? len_d : trim_raw;
		len_m1   = len_d - CW'(1);
		if (strand_eff && trim_x != '0) begin
			nstart = (trim_x < len_m1) ? trim_x : len_m1;
		end else begin
			nstart = '0;
		end
		nend = (EW'(oplen_s1) > EW'(trim_x)) ? EW'(oplen_s1) - EW'(trim_x) : '0;

		result = '0;
		result[10:0]  = rqt_pkg::TRIM_W'(trim_x);
		result[21:11] = rqt_pkg::NLEN_W'(len_d - trim_x);
		result[31:22] = rqt_pkg::NSTART_W'(nstart);
		result[42:32] = rqt_pkg::NEND_W'(nend);
	end

	// read state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q   <= '0;
			best_sum_q      <= rqt_pkg::SUM_MIN;
			best_position_q <= '0;
			base_count_q    <= '0;
			no_trim_q       <= 1'b0;
			strand_q        <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				running_sum_q   <= '0;
				best_sum_q      <= rqt_pkg::SUM_MIN;
				best_position_q <= '0;
				base_count_q    <= '0;
				no_trim_q       <= 1'b0;
				strand_q        <= 1'b0;
			end else begin
				running_sum_q   <= running_sum_d;
				best_sum_q      <= best_sum_d;
				best_position_q <= best_position_d;
				base_count_q    <= len_d;
				no_trim_q       <= active ? no_trim_eff : no_trim_q;
				strand_q        <= active ? strand_eff : strand_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			m_data_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// assertions
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && m_valid_q && !m_tready))
		else $error("input stalled without a pending result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		base_count_q <= MAX_LEN)
		else $error("base count beyond maximum read length");

	a_best_dominates: assert property (@(posedge clk) disable iff (!arst_n)
		(base_count_q != '0 && !no_trim_q) |-> $signed(running_sum_q) <= $signed(best_sum_q))
		else $error("running sum above best sum");

	a_start_le_trim: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q[31:22] <= m_data_q[10:0]))
		else $error("start offset beyond trim count");

endmodule

/* tb/sv/read_quality_trimmer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_quality_trimmer_unit_tb
// Self-checking stream testbench for the 3'-end read quality trimmer.
// ----------------------------------------------------------------------------
// Reads are sent as quality byte transactions with tlast on the final byte.
// A scoreboard predicts the trim result of every read from the accepted
// transactions and checks each result transaction against it in order.
// A short directed set covers no-trim reads, whole-read trims, reverse
// strand and bytes above the printable range. Random reads follow under
// several threshold and encoding settings, with random gaps and stalls, a
// stretch without idling and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module read_quality_trimmer_unit_tb;

	localparam int MAX_BASES   = 1024;
	localparam int SUM_HI      = 2 ** (rqt_pkg::SUM_W - 1) - 1;
	localparam int SUM_LO      = -(2 ** (rqt_pkg::SUM_W - 1));
	localparam int QUAL_OFFSET [4] = '{33, 59, 64, 66};
	localparam int LONG_HOLD   = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 85;

	typedef struct packed {
		logic [rqt_pkg::TRIM_W-1:0]   trim_count;
		logic [rqt_pkg::NLEN_W-1:0]   new_length;
		logic [rqt_pkg::NSTART_W-1:0] start_offset;
		logic [rqt_pkg::NEND_W-1:0]   new_end_op_length;
	} trim_result_t;

	class trim_tracker;
		logic [rqt_pkg::THR_W-1:0] threshold;
		logic [rqt_pkg::ENC_W-1:0] encoding;
		int               run_sum;
		int               peak_sum;
		int unsigned      peak_pos;
		int unsigned      bases;
		bit               keep_all;
		bit               reverse;
		trim_result_t     pending_trims[$];
		int               mismatches;

		function new();
			threshold  = rqt_pkg::THR_RESET;
			encoding   = rqt_pkg::ENC_RESET;
			mismatches = 0;
			clear_read();
		endfunction

		function void clear_read();
			run_sum  = 0;
			peak_sum = SUM_LO;
			peak_pos = 0;
			bases    = 0;
			keep_all = 0;
			reverse  = 0;
		endfunction

		function void write_reg(logic idx, logic [rqt_pkg::CFG_W-1:0] val);
			if (idx == rqt_pkg::REG_TRIM_THRESHOLD) begin
				threshold = val[rqt_pkg::THR_W-1:0];
			end else begin
				encoding = val[rqt_pkg::ENC_W-1:0];
			end
		endfunction

		function void note_base(logic [rqt_pkg::QUAL_W-1:0] qual, logic last, logic rev,
				logic [rqt_pkg::OPLEN_W-1:0] op_len);
			int           q;
			int           thr;
			int           s;
			int unsigned  cut;
			int unsigned  kept_start;
			int unsigned  clip;
			trim_result_t r;
			q   = int'(qual) - QUAL_OFFSET[encoding];
			thr = int'(threshold);
			if (bases < MAX_BASES) begin
				if (bases == 0) begin
					reverse  = rev;
					keep_all = (q >= thr);
				end
				if (!keep_all) begin
					s = run_sum + thr - q;
					if (s > SUM_HI) s = SUM_HI;
					if (s < SUM_LO) s = SUM_LO;
					run_sum = s;
					if (s > peak_sum) begin
						peak_sum = s;
						peak_pos = bases;
					end
				end
				bases++;
			end
			if (!last) return;
			cut = keep_all ? 0 : peak_pos + 1;
			if (cut > bases) cut = bases;
			kept_start = 0;
			if (reverse && cut > 0) kept_start = (cut < bases - 1) ? cut : bases - 1;
			clip = (op_len > cut) ? op_len - cut : 0;
			r.trim_count        = rqt_pkg::TRIM_W'(cut);
			r.new_length        = rqt_pkg::NLEN_W'(bases - cut);
			r.start_offset      = rqt_pkg::NSTART_W'(kept_start);
			r.new_end_op_length = rqt_pkg::NEND_W'(clip);
			pending_trims = {pending_trims, r};
			clear_read();
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [rqt_pkg::M_DATA_W-1:0] d);
			trim_result_t want;
			if (pending_trims.size() == 0) begin
				$display("%0t: result with no read pending, actual trim %0d length %0d",
					$time, d[10:0], d[21:11]);
				mismatches++;
				return;
			end
			want = pending_trims.pop_front();
			compare_field("trim_count", want.trim_count, d[10:0]);
			compare_field("new_length", want.new_length, d[21:11]);
			compare_field("start_offset", want.start_offset, d[31:22]);
			compare_field("new_end_op_length", want.new_end_op_length, d[42:32]);
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic                          cfg_index;
	logic [rqt_pkg::CFG_W-1:0]     cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [rqt_pkg::S_DATA_W-1:0]  s_tdata;
	logic                          s_tlast;
	logic                          s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [rqt_pkg::M_DATA_W-1:0]  m_tdata;

	trim_tracker                   tracker = new();
	logic [rqt_pkg::QUAL_W-1:0]    read_buf[$];
	bit                            quiet;
	bit                            hold_pending;

	read_quality_trimmer_unit #(
		.MAX_READ_LENGTH(MAX_BASES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_base(input logic [rqt_pkg::QUAL_W-1:0] qual, input logic last,
			input logic rev, input logic [rqt_pkg::OPLEN_W-1:0] op_len);
		int r;
		int gap;
		r   = $urandom_range(0, 99);
		gap = quiet ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {{(rqt_pkg::S_DATA_W - rqt_pkg::OPLEN_W - rqt_pkg::QUAL_W){1'b0}},
			op_len, qual};
		s_tlast  <= last;
		s_tuser  <= rev;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tracker.note_base(qual, last, rev, op_len);
	endtask

	task automatic send_read(input logic rev, input logic [rqt_pkg::OPLEN_W-1:0] op_len);
		int n;
		n = read_buf.size();
		for (int i = 0; i < n; i++) begin
			send_base(read_buf[i], i == n - 1,
				(i == 0) ? rev : 1'($urandom_range(0, 1)),
				(i == n - 1) ? op_len : rqt_pkg::OPLEN_W'($urandom_range(0, 1024)));
		end
	endtask

	task automatic make_read(input int len);
		int style;
		int level;
		int v;
		read_buf.delete();
		style = $urandom_range(0, 99);
		level = QUAL_OFFSET[tracker.encoding] + int'(tracker.threshold);
		for (int i = 0; i < len; i++) begin
			if (style < 25) begin
				v = $urandom_range(0, 255);
			end else if (i == 0) begin
				v = (style < 40) ? level + $urandom_range(0, 10) : level - 1 - $urandom_range(0, 10);
			end else begin
				v = level + $urandom_range(0, 24) - 12;
			end
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			read_buf = {read_buf, rqt_pkg::QUAL_W'(v)};
		end
	endtask

	task automatic random_reads(input int items);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < items) begin
			r   = $urandom_range(0, 99);
			len = (r < 80) ? $urandom_range(1, 24) :
				(r < 97) ? $urandom_range(25, 150) : $urandom_range(151, 400);
			make_read(len);
			r = $urandom_range(0, 99);
			send_read(1'($urandom_range(0, 1)),
				rqt_pkg::OPLEN_W'((r < 50) ? $urandom_range(0, 30) : $urandom_range(0, 1024)));
			sent += len;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending_trims.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [rqt_pkg::THR_W-1:0] thr,
			input logic [rqt_pkg::ENC_W-1:0] enc);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= rqt_pkg::REG_TRIM_THRESHOLD;
		cfg_data  <= rqt_pkg::CFG_W'(thr);
		@(posedge clk);
		tracker.write_reg(rqt_pkg::REG_TRIM_THRESHOLD, rqt_pkg::CFG_W'(thr));
		cfg_index <= rqt_pkg::REG_ENCODING_SELECT;
		cfg_data  <= rqt_pkg::CFG_W'(enc);
		@(posedge clk);
		tracker.write_reg(rqt_pkg::REG_ENCODING_SELECT, rqt_pkg::CFG_W'(enc));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [rqt_pkg::THR_W-1:0] phase_thr [6];
		logic [rqt_pkg::ENC_W-1:0] phase_enc [6];
		phase_thr = '{7'd0, 7'd93, 7'd35, 7'd7, 7'd93, 7'd0};
		phase_enc = '{rqt_pkg::ENC_PHRED66, rqt_pkg::ENC_PHRED33, rqt_pkg::ENC_PHRED59,
			rqt_pkg::ENC_PHRED64, rqt_pkg::ENC_PHRED64, rqt_pkg::ENC_PHRED33};
		phase_thr[5] = rqt_pkg::THR_W'($urandom_range(0, 93));
		phase_enc[5] = rqt_pkg::ENC_W'($urandom_range(0, 3));
		quiet        = 1'b0;
		hold_pending = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= rqt_pkg::REG_TRIM_THRESHOLD;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		s_tuser   <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		read_buf = {8'd33};
		send_read(1'b0, 11'd0);
		read_buf = {8'd0};
		send_read(1'b1, 11'd1024);
		read_buf = {8'd53, 8'd0, 8'd255};
		send_read(1'b1, 11'd1023);
		read_buf = {8'd35, 8'd40, 8'd60, 8'd70};
		send_read(1'b1, 11'd2);
		read_buf = {8'd52, 8'd200, 8'd255, 8'd128, 8'd10};
		send_read(1'b0, 11'd1024);
		read_buf = {8'd43, 8'd53, 8'd43};
		send_read(1'b0, 11'd5);
		read_buf = {8'd1, 8'd2, 8'd3};
		send_read(1'b1, 11'd3);
		read_buf = {8'd127, 8'd254};
		send_read(1'b1, 11'd700);

		for (int p = 0; p < 6; p++) begin
			set_config(phase_thr[p], phase_enc[p]);
			quiet = (p == 3);
			if (p == 2) hold_pending = 1'b1;
			random_reads(PHASE_ITEMS);
		end
		quiet = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		int stall;
		int r;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) tracker.check_result(m_tdata);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule
